[rtl/pid_controller_step_assert.svh]
// assertion macros for the pid controller step block
// expects aclk and aresetn in the scope of each use
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define PCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// checked on every edge, reset included
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define PCS_ASSERT(lbl, prop, msg)
`define PCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/pid_pkg.sv]
// shared widths, register indexes and beat types for the pid controller step
// no dependencies
package pid_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int GAIN_WIDTH = 24;
    localparam int FRAC_BITS  = 16;

    localparam int NUM_REGS = 6;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int ADDR_W = REG_IDX_W + 2;
    localparam int APB_DW = 32;

    localparam logic [REG_IDX_W-1:0] REG_KP      = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_KI      = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_KD      = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_OUT_MIN = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_OUT_MAX = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_REVERSE = REG_IDX_W'(5);

    localparam logic [DATA_WIDTH-1:0] OUT_MAX_RESET = DATA_WIDTH'(255);

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] kp;
        logic [GAIN_WIDTH-1:0] ki;
        logic [GAIN_WIDTH-1:0] kd;
        logic [DATA_WIDTH-1:0] out_min;
        logic [DATA_WIDTH-1:0] out_max;
        logic                  reverse;
    } cfg_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] setpoint;
        logic [DATA_WIDTH-1:0] measurement;
        logic [DATA_WIDTH-1:0] manual_output;
        logic                  auto_mode;
    } item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] drive;
        logic                  active;
        logic                  clamped_high;
        logic                  clamped_low;
    } result_t;

endpackage

[rtl/pid_controller_step.sv]
// PID controller step with derivative on measurement, one result beat per sample beat.
// A sample is taken into an input register, and its result is loaded into the output register,
// which drives m_valid, once that register is free or being drained. The block sustains one
// sample per cycle while m_ready stays high. The integral and last-measurement registers are
// updated at the same edge that loads the result; the path from the input register through the
// gain multipliers, the integral clamp, the three-term sum and the output clamp sets the clock
// limit. A stalled output holds its beat while one more sample waits in the input register.
// Depends on pid_pkg, pid_regs, pid_core and pid_controller_step_assert.svh.
`include "pid_controller_step_assert.svh"

module pid_controller_step (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pid_pkg::ADDR_W-1:0]          paddr,
    input  logic [pid_pkg::APB_DW-1:0]          pwdata,
    output logic [pid_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    // samples
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] s_setpoint,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] s_measurement,
    input  logic signed [pid_pkg::DATA_WIDTH-1:0] s_manual_output,
    input  logic                                s_auto_mode,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pid_pkg::DATA_WIDTH-1:0] m_drive,
    output logic                                m_active,
    output logic                                m_clamped_high,
    output logic                                m_clamped_low
);

    pid_pkg::cfg_t    cfg;
    pid_pkg::item_t   in_item_reg;
    pid_pkg::result_t out_res_reg, res;
    logic             in_valid_reg, out_valid_reg;
    logic             advance;

    assign pready = 1'b1;

    pid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pid_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // sample moves on when the output register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{setpoint: s_setpoint, measurement: s_measurement,
                             manual_output: s_manual_output, auto_mode: s_auto_mode};
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_drive        = $signed(out_res_reg.drive);
    assign m_active       = out_res_reg.active;
    assign m_clamped_high = out_res_reg.clamped_high;
    assign m_clamped_low  = out_res_reg.clamped_low;

    `PCS_ASSERT(a_manual_no_flags, m_valid && !m_active |-> !m_clamped_high && !m_clamped_low, "manual beat carries a clamp flag")
    `PCS_ASSERT(a_flags_exclusive, m_valid |-> !(m_clamped_high && m_clamped_low), "both clamp flags set")
    `PCS_ASSERT(a_high_is_max, m_valid && m_clamped_high |-> m_drive == $signed(cfg.out_max), "clamped high but drive differs from out_max")
    `PCS_ASSERT(a_empty_ready, !in_valid_reg && !out_valid_reg |-> s_ready, "empty pipeline refuses a sample")
    `PCS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid && !in_valid_reg, "pipeline not cleared by reset")

endmodule

[rtl/pid_regs.sv]
// apb configuration registers: gains, output limits and action direction
// depends on pid_pkg
module pid_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pid_pkg::ADDR_W-1:0]       paddr,
    input  logic [pid_pkg::APB_DW-1:0]       pwdata,
    output logic [pid_pkg::APB_DW-1:0]       prdata,
    output pid_pkg::cfg_t                    cfg
);

    logic [pid_pkg::GAIN_WIDTH-1:0] kp_reg, ki_reg, kd_reg;
    logic [pid_pkg::DATA_WIDTH-1:0] out_min_reg, out_max_reg;
    logic                           reverse_reg;
    logic [pid_pkg::REG_IDX_W-1:0]  idx;
    logic                           wr_en;

    assign idx   = paddr[pid_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            out_min_reg <= '0;
            out_max_reg <= pid_pkg::OUT_MAX_RESET;
            reverse_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                pid_pkg::REG_KP:      kp_reg      <= pwdata[pid_pkg::GAIN_WIDTH-1:0];
                pid_pkg::REG_KI:      ki_reg      <= pwdata[pid_pkg::GAIN_WIDTH-1:0];
                pid_pkg::REG_KD:      kd_reg      <= pwdata[pid_pkg::GAIN_WIDTH-1:0];
                pid_pkg::REG_OUT_MIN: out_min_reg <= pwdata[pid_pkg::DATA_WIDTH-1:0];
                pid_pkg::REG_OUT_MAX: out_max_reg <= pwdata[pid_pkg::DATA_WIDTH-1:0];
                pid_pkg::REG_REVERSE: reverse_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            pid_pkg::REG_KP:      prdata = pid_pkg::APB_DW'(kp_reg);
            pid_pkg::REG_KI:      prdata = pid_pkg::APB_DW'(ki_reg);
            pid_pkg::REG_KD:      prdata = pid_pkg::APB_DW'(kd_reg);
            pid_pkg::REG_OUT_MIN: prdata = pid_pkg::APB_DW'(out_min_reg);
            pid_pkg::REG_OUT_MAX: prdata = pid_pkg::APB_DW'(out_max_reg);
            pid_pkg::REG_REVERSE: prdata = pid_pkg::APB_DW'(reverse_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg = '{kp: kp_reg, ki: ki_reg, kd: kd_reg, out_min: out_min_reg,
                   out_max: out_max_reg, reverse: reverse_reg};

endmodule

[rtl/pid_core.sv]
// pid arithmetic and controller state (integral, last measurement, mode)
// depends on pid_pkg
module pid_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  pid_pkg::item_t   item,
    input  pid_pkg::cfg_t    cfg,
    output pid_pkg::result_t res
);

    localparam int DW     = pid_pkg::DATA_WIDTH;
    localparam int FB     = pid_pkg::FRAC_BITS;
    localparam int ERR_W  = DW + 1;
    localparam int GS_W   = pid_pkg::GAIN_WIDTH + 1;
    localparam int PROD_W = GS_W + ERR_W;
    localparam int INT_W  = DW + FB;
    localparam int ACC_W  = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;
    localparam int SUM_W  = ACC_W + 1;

    logic signed [INT_W-1:0]  integral_reg, integral_next;
    logic signed [DW-1:0]     last_meas_reg;
    logic                     was_auto_reg;

    logic signed [DW-1:0]     sp, meas, man, lo, hi, last_base;
    logic signed [ERR_W-1:0]  err, din;
    logic signed [INT_W-1:0]  lo_f, hi_f, seed, int_base;
    logic signed [GS_W-1:0]   kp_s, ki_s, kd_s;
    logic signed [PROD_W-1:0] p_kp, p_ki, p_kd;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SUM_W-1:0]  sum, y_full;

    always_comb begin
        sp   = $signed(item.setpoint);
        meas = $signed(item.measurement);
        man  = $signed(item.manual_output);
        lo   = $signed(cfg.out_min);
        hi   = $signed(cfg.out_max);
        lo_f = $signed({cfg.out_min, {FB{1'b0}}});
        hi_f = $signed({cfg.out_max, {FB{1'b0}}});

        // bumpless entry: seed from the clamped manual value
        seed = $signed({man, {FB{1'b0}}});
        if (seed > hi_f) begin
            seed = hi_f;
        end else if (seed < lo_f) begin
            seed = lo_f;
        end
        int_base  = was_auto_reg ? integral_reg : seed;
        last_base = was_auto_reg ? last_meas_reg : meas;

        err = ERR_W'(sp) - ERR_W'(meas);
        din = ERR_W'(meas) - ERR_W'(last_base);

        kp_s = $signed({1'b0, cfg.kp});
        ki_s = $signed({1'b0, cfg.ki});
        kd_s = $signed({1'b0, cfg.kd});
        p_kp = PROD_W'(kp_s) * PROD_W'(err);
        p_ki = PROD_W'(ki_s) * PROD_W'(err);
        p_kd = PROD_W'(kd_s) * PROD_W'(din);
        if (cfg.reverse) begin
            p_kp = -p_kp;
            p_ki = -p_ki;
            p_kd = -p_kd;
        end

        acc = ACC_W'(int_base) + ACC_W'(p_ki);
        if (acc > ACC_W'(hi_f)) begin
            integral_next = hi_f;
        end else if (acc < ACC_W'(lo_f)) begin
            integral_next = lo_f;
        end else begin
            integral_next = acc[INT_W-1:0];
        end

        sum    = SUM_W'(p_kp) + SUM_W'(integral_next) - SUM_W'(p_kd);
        y_full = sum >>> FB;

        res = '0;
        if (!item.auto_mode) begin
            res.drive = item.manual_output;
        end else begin
            res.active = 1'b1;
            if (y_full > SUM_W'(hi)) begin
                res.drive        = cfg.out_max;
                res.clamped_high = 1'b1;
            end else if (y_full < SUM_W'(lo)) begin
                res.drive       = cfg.out_min;
                res.clamped_low = 1'b1;
            end else begin
                res.drive = y_full[DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg  <= '0;
            last_meas_reg <= '0;
            was_auto_reg  <= 1'b0;
        end else if (step) begin
            if (item.auto_mode) begin
                integral_reg  <= integral_next;
                last_meas_reg <= meas;
                was_auto_reg  <= 1'b1;
            end else begin
                was_auto_reg  <= 1'b0;
            end
        end
    end

endmodule
